// ----- design/mnt_pkg.sv -----
// Shared types and constants for the MIDI note tracker.
// Used by the front parser, the command queue, the back end and the top level.
`default_nettype none

package mnt_pkg;

	// Status nibbles that touch the held-note map
	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

	// Status bytes that set the data count
	localparam logic [7:0] ST_SYS_FIRST  = 8'hA0;
	localparam logic [7:0] ST_PROG       = 8'hC0;
	localparam logic [7:0] ST_BEND       = 8'hE0;
	localparam logic [7:0] ST_SENSE      = 8'hFE;

	localparam logic [1:0] LEFT_NONE     = 2'd0;
	localparam logic [1:0] LEFT_ONE      = 2'd1;
	localparam logic [1:0] LEFT_TWO      = 2'd2;

	localparam int NOTE_W    = 7;
	localparam int NOTES     = 1 << NOTE_W;
	localparam int HALF_W    = NOTES / 2;

	// Command queue between front and back
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic              ev;
		logic              on;
		logic [NOTE_W-1:0] note;
	} note_cmd_t;

endpackage : mnt_pkg

`default_nettype wire

// ----- design/mnt_front.sv -----
// Front end: accepts received bytes, tracks running status and data count,
// and turns each byte into a note command. Depends on mnt_pkg.
`default_nettype none

module mnt_front import mnt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic [7:0]      rx_byte,
	output note_cmd_t       cmd
);

	logic [7:0]        status_q;
	logic [NOTE_W-1:0] note_q;
	logic [1:0]        left_q;

	logic [7:0]        status_d;
	logic [NOTE_W-1:0] note_d;
	logic [1:0]        left_d;
	logic [3:0]        kind;

	assign kind = status_q[7:4];

	always_comb begin
		status_d = status_q;
		note_d   = note_q;
		left_d   = left_q;
		cmd      = '0;
		if (rx_byte >= ST_SYS_FIRST) begin
			status_d = rx_byte;
			if (rx_byte == ST_BEND) begin
				left_d = LEFT_TWO;
			end else if (rx_byte == ST_PROG) begin
				left_d = LEFT_ONE;
			end else if (rx_byte != ST_SENSE) begin
				left_d = LEFT_NONE;
			end
		end else if (rx_byte[7]) begin
			status_d = rx_byte;
			left_d   = LEFT_TWO;
		end else begin
			// consume a data byte; the first of two is the note
			if (left_q != LEFT_NONE) begin
				left_d = left_q - 2'd1;
			end
			if (left_q == LEFT_TWO) begin
				note_d = rx_byte[NOTE_W-1:0];
			end
			if (left_d == LEFT_NONE && (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON)) begin
				cmd.ev   = 1'b1;
				cmd.on   = (kind == KIND_NOTE_ON);
				cmd.note = note_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			note_q   <= '0;
			left_q   <= LEFT_NONE;
		end else if (in_valid && !in_stall) begin
			status_q <= status_d;
			note_q   <= note_d;
			left_q   <= left_d;
		end
	end

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q != 2'd3)
		else $error("data count out of range");

endmodule : mnt_front

`default_nettype wire

// ----- design/mnt_queue.sv -----
// Short command queue between the front parser and the back end.
// Depends on mnt_pkg for the command type and depth.
`default_nettype none

module mnt_queue import mnt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  note_cmd_t push_cmd,
	input  logic      pop,
	output note_cmd_t pop_cmd,
	output logic      full,
	output logic      not_empty
);

	note_cmd_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule : mnt_queue

`default_nettype wire

// ----- design/mnt_back.sv -----
// Back end: applies note commands to the held-note map and holds the
// result word until it is taken. Depends on mnt_pkg.
`default_nettype none

module mnt_back import mnt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_avail,
	input  note_cmd_t         cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [NOTES-1:0]  held,
	output logic              event_valid,
	output logic [NOTE_W-1:0] event_note,
	output logic              event_on
);

	logic [NOTES-1:0]  held_q;
	logic              valid_q;
	note_cmd_t         ev_q;
	logic [NOTES-1:0]  held_d;

	// advance when the result register is free or being taken
	assign pop = cmd_avail && (!valid_q || !out_stall);

	always_comb begin
		held_d = held_q;
		if (cmd.ev) begin
			held_d[cmd.note] = cmd.on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			valid_q <= 1'b0;
			ev_q    <= '0;
		end else begin
			if (pop) begin
				held_q  <= held_d;
				ev_q    <= cmd;
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign held        = held_q;
	assign event_valid = ev_q.ev;
	assign event_note  = ev_q.note;
	assign event_on    = ev_q.on;

	a_map_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(held_q))
		else $error("held map changed without a command");

	a_on_needs_event: assert property (@(posedge clk) disable iff (!arst_n)
		ev_q.on |-> ev_q.ev)
		else $error("note on flagged without an event");

endmodule : mnt_back

`default_nettype wire

// ----- design/midi_note_tracker_core.sv -----
// Top level of the MIDI note tracker: front parser, command queue, back end.
// Depends on mnt_pkg, mnt_front, mnt_queue and mnt_back.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  rx_byte
//   output   out_valid/ out_stall held_low, held_high, event_valid, event_note, event_on
//
// One word per cycle sustained while out_stall stays low; a taken word's
// command goes from the front into the queue at the taking edge, and from
// the queue into the result register when the back end pops it.
// Under output stall the two-entry queue takes up to two more words (one when
// it already holds one) before in_stall rises.
// Reset clears the parser state, the queue and the held-note map at once.
`default_nettype none

module midi_note_tracker_core import mnt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [63:0]       held_low,
	output logic [63:0]       held_high,
	output logic              event_valid,
	output logic [NOTE_W-1:0] event_note,
	output logic              event_on
);

	note_cmd_t        front_cmd;
	note_cmd_t        queue_cmd;
	logic             q_full;
	logic             q_avail;
	logic             q_pop;
	logic [NOTES-1:0] held;

	assign in_stall = q_full;

	mnt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.cmd      (front_cmd)
	);

	mnt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_cmd  (front_cmd),
		.pop       (q_pop),
		.pop_cmd   (queue_cmd),
		.full      (q_full),
		.not_empty (q_avail)
	);

	mnt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_avail   (q_avail),
		.cmd         (queue_cmd),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.held        (held),
		.event_valid (event_valid),
		.event_note  (event_note),
		.event_on    (event_on)
	);

	assign held_low  = held[HALF_W-1:0];
	assign held_high = held[NOTES-1:HALF_W];

endmodule : midi_note_tracker_core

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for midi_note_tracker_core: feeds MIDI bytes and checks every output word
// against a local note tracker. Depends on mnt_pkg and the core's RTL only.

module tb_top;
	import mnt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int PRINT_CAP    = 100;

	// System bytes used as plain status values
	localparam logic [7:0] ST_SYS_EXCL  = 8'hF0;
	localparam logic [7:0] ST_SYS_RESET = 8'hFF;

	typedef struct packed {
		logic [63:0]       held_low;
		logic [63:0]       held_high;
		logic              ev;
		logic [NOTE_W-1:0] note;
		logic              on;
	} note_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        rx_byte = 8'h00;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [63:0]       held_low;
	logic [63:0]       held_high;
	logic              event_valid;
	logic [NOTE_W-1:0] event_note;
	logic              event_on;

	// Tracker state
	logic [7:0]        trk_status = '0;
	logic [NOTE_W-1:0] trk_note = '0;
	logic [1:0]        trk_left = LEFT_NONE;
	logic [NOTES-1:0]  trk_held = '0;

	logic [7:0]   pending_bytes[$];
	note_word_t   expected_words[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit pressure_on = 1'b0;
	bit hold_used = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int cycle_count = 0;
	int bytes_taken = 0;
	int words_seen = 0;
	int ons_seen = 0;
	int offs_seen = 0;
	int stall_seen = 0;

	midi_note_tracker_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.held_low   (held_low),
		.held_high  (held_high),
		.event_valid(event_valid),
		.event_note (event_note),
		.event_on   (event_on)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		// cap the printing, keep counting
		if (errors < PRINT_CAP)
			$display("tb_top: mismatch on %s at cycle %0d: got %h, want %h",
				what, cycle_count, got, want);
		errors++;
	endtask

	function automatic note_word_t track_byte(input logic [7:0] b);
		note_word_t w;
		logic [3:0] kind;
		w = '0;
		if (b >= ST_SYS_FIRST) begin
			trk_status = b;
			if (b == ST_BEND)
				trk_left = LEFT_TWO;
			else if (b == ST_PROG)
				trk_left = LEFT_ONE;
			else if (b != ST_SENSE)
				trk_left = LEFT_NONE;
		end else if (b[7]) begin
			trk_status = b;
			trk_left = LEFT_TWO;
		end else begin
			if (trk_left != LEFT_NONE) begin
				if (trk_left == LEFT_TWO)
					trk_note = b[NOTE_W-1:0];
				trk_left = trk_left - 2'd1;
			end
			// count spent: a note status applies to the stored note, even on running data
			if (trk_left == LEFT_NONE) begin
				kind = trk_status[7:4];
				if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) begin
					w.ev = 1'b1;
					w.note = trk_note;
					w.on = (kind == KIND_NOTE_ON);
					trk_held[trk_note] = w.on;
				end
			end
		end
		w.held_low = trk_held[HALF_W-1:0];
		w.held_high = trk_held[NOTES-1:HALF_W];
		return w;
	endfunction

	// Driver: offer the next pending byte, hold it while stalled
	always @(posedge clk or negedge arst_n) begin : drive
		logic       next_valid;
		logic [7:0] next_byte;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			next_valid = in_valid;
			next_byte = rx_byte;
			if (in_valid && in_stall)
				stall_seen++;
			if (in_valid && !in_stall) begin
				expected_words.push_back(track_byte(rx_byte));
				bytes_taken++;
				next_valid = 1'b0;
			end
			if (!next_valid && pending_bytes.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				next_valid = 1'b1;
				next_byte = pending_bytes.pop_front();
			end
			in_valid <= next_valid;
			rx_byte <= next_byte;
		end
	end

	// Long receiver hold-off, once, when the pressure phase starts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (pressure_on && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// Monitor: compare each accepted word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : watch
		note_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					report_mismatch("word with none expected", 64'd0, 64'd0);
				end else begin
					want = expected_words.pop_front();
					if (held_low !== want.held_low)
						report_mismatch("held_low", held_low, want.held_low);
					if (held_high !== want.held_high)
						report_mismatch("held_high", held_high, want.held_high);
					if (event_valid !== want.ev)
						report_mismatch("event_valid", 64'(event_valid), 64'(want.ev));
					if (event_note !== want.note)
						report_mismatch("event_note", 64'(event_note), 64'(want.note));
					if (event_on !== want.on)
						report_mismatch("event_on", 64'(event_on), 64'(want.on));
					if (want.ev && want.on)
						ons_seen++;
					else if (want.ev)
						offs_seen++;
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_top: timed out after %0d cycles", cycle_count);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic logic [NOTE_W-1:0] pick_note();
		// favour both ends of the range so offs often hit held notes
		if ($urandom_range(1))
			return NOTE_W'($urandom_range(NOTES - 1));
		return {$urandom_range(1) ? 3'b111 : 3'b000, 4'($urandom_range(15))};
	endfunction

	task automatic queue_message();
		int         pick;
		int         n;
		logic [3:0] ch;
		pick = $urandom_range(99);
		ch = 4'($urandom_range(15));
		if (pick < 30) begin
			pending_bytes.push_back({KIND_NOTE_ON, ch});
			pending_bytes.push_back({1'b0, pick_note()});
			pending_bytes.push_back(8'($urandom_range(127)));
		end else if (pick < 55) begin
			pending_bytes.push_back({KIND_NOTE_OFF, ch});
			pending_bytes.push_back({1'b0, pick_note()});
			pending_bytes.push_back(8'($urandom_range(127)));
		end else if (pick < 65) begin
			// running data on whatever status stands
			n = $urandom_range(3, 1);
			repeat (n) pending_bytes.push_back(8'($urandom_range(127)));
		end else if (pick < 71) begin
			pending_bytes.push_back(ST_BEND);
			pending_bytes.push_back(8'($urandom_range(127)));
			pending_bytes.push_back(8'($urandom_range(127)));
		end else if (pick < 77) begin
			pending_bytes.push_back(ST_PROG);
			pending_bytes.push_back(8'($urandom_range(127)));
		end else if (pick < 81) begin
			pending_bytes.push_back(ST_SENSE);
			if ($urandom_range(1))
				pending_bytes.push_back(8'($urandom_range(127)));
		end else if (pick < 86) begin
			pending_bytes.push_back(8'($urandom_range(255, 160)));
		end else if (pick < 93) begin
			// cut-short note message, next message interrupts it
			pending_bytes.push_back({$urandom_range(1) ? KIND_NOTE_ON : KIND_NOTE_OFF, ch});
			if ($urandom_range(1))
				pending_bytes.push_back({1'b0, pick_note()});
		end else begin
			pending_bytes.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic wait_drain();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input bit pressure,
			input int n_bytes);
		@(negedge clk);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		pressure_on = pressure;
		while (pending_bytes.size() < n_bytes)
			queue_message();
		wait_drain();
		pressure_on = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// data before any status, velocity-zero on, running data, active sense
		// mid-message, program and bend data, system bytes, both ends of the note range
		pending_bytes = '{8'h00, 8'h7F,
			{KIND_NOTE_ON, 4'h0}, 8'h00, 8'h00,
			{KIND_NOTE_ON, 4'hF}, 8'h7F, 8'h7F,
			8'h55,
			{KIND_NOTE_OFF, 4'h0}, 8'h00, 8'h40,
			ST_BEND, 8'h45, 8'h12,
			ST_PROG, 8'h05,
			{KIND_NOTE_ON, 4'h3}, 8'h40, ST_SENSE, 8'h22,
			ST_SYS_RESET, ST_SYS_FIRST, ST_SYS_EXCL,
			{KIND_NOTE_OFF, 4'hF}, 8'h7F, 8'h00};
		wait_drain();

		run_phase(0, 0, 1'b0, 250);
		run_phase(85, 0, 1'b0, 200);
		run_phase(0, 85, 1'b0, 200);
		run_phase(10, 10, 1'b0, 250);
		run_phase(0, 0, 1'b1, 150);

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch("words still expected", 64'(expected_words.size()), 64'd0);

		$display("tb_top: %0d bytes taken, %0d words checked, %0d note ons, %0d note offs",
			bytes_taken, words_seen, ons_seen, offs_seen);
		$display("tb_top: idle and stall phases plus one long hold-off, %0d input stall cycles",
			stall_seen);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
